FILE: hw/rtl/min_heap_timer_queue_top_assert.svh
// Assertion macros for the timer queue.
`ifndef MIN_HEAP_TIMER_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, reset masked.
`define MHTQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Next-cycle implication, reset masked.
`define MHTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

FILE: hw/rtl/mhtq_pkg.sv
`default_nettype none
package mhtq_pkg;
    localparam int DL_BITS       = 32;
    localparam int TAG_PORT_BITS = 16;
    localparam int DELAY_BITS    = 20;
    localparam int KIND_BITS     = 2;
    localparam int MAX_RESULTS   = 64;
    localparam int POP_CNT_BITS  = $clog2(MAX_RESULTS + 1);

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_EXPIRE = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FIRED    = 2'd2;
endpackage
`default_nettype wire

FILE: hw/rtl/mhtq_ram.sv
`default_nettype none
module mhtq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds data when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/min_heap_timer_queue_top.sv
// Timer queue: binary min-heap in one synchronous RAM (one read, one write port).
// Add: result registered in ST_ADD_RES when output is free; sift-up: ST_UP_CHK, ST_UP_CMP.
// Expire: ST_EX_CHK, ST_EX_ROOT test the root; each pop adds ST_DN_LAST and a sift-down.
// Input stalls while a walk runs; the next item is taken back in ST_IDLE.
// Reset (rst_n, async, active low) empties the queue; RAM contents are not cleared.
`default_nettype none
module min_heap_timer_queue_top #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [31:0] now,
    input  wire logic [19:0] delay,
    input  wire logic [15:0] tag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [15:0]      fired_tag,
    output logic [31:0]      deadline,
    output logic             last
);
    localparam int TW = (TAG_BITS < mhtq_pkg::TAG_PORT_BITS) ? TAG_BITS
                                                           : mhtq_pkg::TAG_PORT_BITS;
    localparam int EW = mhtq_pkg::DL_BITS + TW;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int PW = mhtq_pkg::POP_CNT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD_RES, ST_UP_CHK, ST_UP_CMP, ST_EX_CHK, ST_EX_ROOT,
        ST_DN_LAST, ST_DN_CHK, ST_DN_A, ST_DN_B, ST_DN_CMP, ST_EX_END
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      cidx_reg;
    logic [PW-1:0]      pops_reg;
    logic [31:0]        now_reg;
    logic [31:0]        e_dl_reg;
    logic [TW-1:0]      e_tag_reg;
    logic [EW-1:0]      child_reg;
    logic               pend_valid_reg;
    logic [EW-1:0]      pend_reg;
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        tag_reg;
    logic [31:0]        dl_reg;
    logic               last_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [EW-1:0]      mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [EW-1:0]      mem_rdata;

    logic [32:0]        sum;
    logic [31:0]        dl_sat;
    logic               out_free;
    logic               out_load;
    logic [EW-1:0]      e_word;
    logic [31:0]        rd_dl;
    logic [31:0]        child_dl;
    logic [IW-1:0]      a_idx;
    logic [IW-1:0]      b_idx;
    logic [IW-1:0]      cnt_w;
    logic [AW-1:0]      parent_idx;
    logic               root_due;
    logic               can_emit;

    // Saturating deadline
    assign sum    = {1'b0, now} + 33'(delay);
    assign dl_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    assign out_free   = !out_valid_reg || !out_stall;
    assign e_word     = {e_dl_reg, e_tag_reg};
    assign rd_dl      = mem_rdata[EW-1 -: 32];
    assign child_dl   = child_reg[EW-1 -: 32];
    assign a_idx      = {1'b0, idx_reg, 1'b1};
    assign b_idx      = a_idx + IW'(1);
    assign cnt_w      = IW'(count_reg);
    assign parent_idx = AW'((idx_reg - AW'(1)) >> 1);
    assign root_due   = rd_dl <= now_reg;
    assign can_emit   = !pend_valid_reg || out_free;

    // Load a new output word this cycle
    assign out_load = ((state_reg == ST_ADD_RES) && out_free)
                   || ((state_reg == ST_EX_ROOT) && root_due && can_emit && pend_valid_reg)
                   || ((state_reg == ST_EX_END) && pend_valid_reg && out_free);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = tag_reg;
    assign deadline  = dl_reg;
    assign last      = last_reg;

    mhtq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Drive RAM ports from the walk state
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = e_word;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            ST_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_idx;
                end
            end
            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if (rd_dl > e_dl_reg)
                begin
                    mem_wdata = mem_rdata;
                end
            end
            ST_EX_CHK:
            begin
                if (pops_reg != PW'(mhtq_pkg::MAX_RESULTS) && count_reg != '0)
                begin
                    mem_re = 1'b1;
                end
            end
            ST_EX_ROOT:
            begin
                if (root_due && can_emit)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(count_reg - CW'(1));
                end
            end
            ST_DN_CHK:
            begin
                if (a_idx < cnt_w)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(a_idx);
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            ST_DN_A:
            begin
                if (b_idx < cnt_w)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(b_idx);
                end
            end
            ST_DN_CMP:
            begin
                mem_we = 1'b1;
                if (child_dl < e_dl_reg)
                begin
                    mem_wdata = child_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer and output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pops_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg        <= now;
                        e_dl_reg       <= dl_sat;
                        e_tag_reg      <= tag[TW-1:0];
                        pops_reg       <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= (action == mhtq_pkg::ACT_ADD) ? ST_ADD_RES
                                                                        : ST_EX_CHK;
                    end
                end
                ST_ADD_RES:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        tag_reg       <= 16'(e_tag_reg);
                        dl_reg        <= e_dl_reg;
                        last_reg      <= 1'b1;
                        if (count_reg == CW'(CAPACITY))
                        begin
                            kind_reg  <= mhtq_pkg::KIND_REJECTED;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            kind_reg  <= mhtq_pkg::KIND_ACCEPTED;
                            idx_reg   <= AW'(count_reg);
                            count_reg <= count_reg + CW'(1);
                            state_reg <= ST_UP_CHK;
                        end
                    end
                end
                ST_UP_CHK:
                begin
                    state_reg <= (idx_reg == '0) ? ST_IDLE : ST_UP_CMP;
                end
                ST_UP_CMP:
                begin
                    if (rd_dl <= e_dl_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= parent_idx;
                        state_reg <= ST_UP_CHK;
                    end
                end
                ST_EX_CHK:
                begin
                    if (pops_reg != PW'(mhtq_pkg::MAX_RESULTS) && count_reg != '0)
                    begin
                        state_reg <= ST_EX_ROOT;
                    end
                    else
                    begin
                        state_reg <= ST_EX_END;
                    end
                end
                ST_EX_ROOT:
                begin
                    if (!root_due)
                    begin
                        state_reg <= ST_EX_END;
                    end
                    else if (can_emit)
                    begin
                        // flush the previous fired word, it is not the last
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= mhtq_pkg::KIND_FIRED;
                            tag_reg       <= 16'(pend_reg[TW-1:0]);
                            dl_reg        <= pend_reg[EW-1 -: 32];
                            last_reg      <= 1'b0;
                        end
                        pend_reg       <= mem_rdata;
                        pend_valid_reg <= 1'b1;
                        pops_reg       <= pops_reg + PW'(1);
                        count_reg      <= count_reg - CW'(1);
                        state_reg      <= ST_DN_LAST;
                    end
                end
                ST_DN_LAST:
                begin
                    e_dl_reg  <= rd_dl;
                    e_tag_reg <= mem_rdata[TW-1:0];
                    idx_reg   <= '0;
                    state_reg <= ST_DN_CHK;
                end
                ST_DN_CHK:
                begin
                    state_reg <= (a_idx < cnt_w) ? ST_DN_A : ST_EX_CHK;
                end
                ST_DN_A:
                begin
                    child_reg <= mem_rdata;
                    cidx_reg  <= AW'(a_idx);
                    state_reg <= (b_idx < cnt_w) ? ST_DN_B : ST_DN_CMP;
                end
                ST_DN_B:
                begin
                    // right child wins only when strictly smaller
                    if (rd_dl < child_dl)
                    begin
                        child_reg <= mem_rdata;
                        cidx_reg  <= AW'(b_idx);
                    end
                    state_reg <= ST_DN_CMP;
                end
                ST_DN_CMP:
                begin
                    if (child_dl >= e_dl_reg)
                    begin
                        state_reg <= ST_EX_CHK;
                    end
                    else
                    begin
                        idx_reg   <= cidx_reg;
                        state_reg <= ST_DN_CHK;
                    end
                end
                ST_EX_END:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        kind_reg       <= mhtq_pkg::KIND_FIRED;
                        tag_reg        <= 16'(pend_reg[TW-1:0]);
                        dl_reg         <= pend_reg[EW-1 -: 32];
                        last_reg       <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "min_heap_timer_queue_top_assert.svh"

    `MHTQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `MHTQ_ASSERT_SAME(a_pop_bound, 1'b1, pops_reg <= PW'(mhtq_pkg::MAX_RESULTS))
    `MHTQ_ASSERT_SAME(a_ram_one_access, 1'b1, !(mem_we && mem_re))
    `MHTQ_ASSERT_NEXT(a_idle_no_pending, state_reg == ST_EX_END && out_free, !pend_valid_reg)

endmodule
`default_nettype wire

FILE: tb/tb_min_heap_timer_queue_top.sv
`default_nettype none
module tb_min_heap_timer_queue_top;

    localparam int CAP        = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_WAIT  = 200;

    typedef struct packed {
        logic        action;
        logic [31:0] now;
        logic [19:0] delay;
        logic [15:0] tag;
    } timer_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_tag;
        logic [31:0] deadline;
        logic        last;
    } timer_evt_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] now;
    logic [19:0] delay;
    logic [15:0] tag;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [15:0] fired_tag;
    logic [31:0] deadline;
    logic        last;

    min_heap_timer_queue_top #(.CAPACITY(CAP), .TAG_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .now(now), .delay(delay), .tag(tag),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .fired_tag(fired_tag), .deadline(deadline), .last(last)
    );

    // heap mirror
    logic [31:0] heap_dl [CAP];
    logic [15:0] heap_tag [CAP];
    int          heap_count;

    timer_req_t  pending_words[$];
    timer_evt_t  expected_events[$];
    int          fail_count;
    int          idle_cycles;
    bit          quiet_tail;
    bit          hold_sender;
    int          receiver_hold;
    int          send_gap;
    int          recv_gap;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void heap_insert(input logic [31:0] dl, input logic [15:0] id);
        int i;
        int p;
        i = heap_count;
        heap_count++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (heap_dl[p] <= dl)
                break;
            heap_dl[i] = heap_dl[p];
            heap_tag[i] = heap_tag[p];
            i = p;
        end
        heap_dl[i] = dl;
        heap_tag[i] = id;
    endfunction

    function automatic void heap_pop_root();
        logic [31:0] mdl;
        logic [15:0] mtag;
        int i;
        int a;
        i = 0;
        heap_count--;
        mdl = heap_dl[heap_count];
        mtag = heap_tag[heap_count];
        while (i * 2 + 1 < heap_count)
        begin
            a = i * 2 + 1;
            if (a + 1 < heap_count && heap_dl[a + 1] < heap_dl[a])
                a = a + 1;
            if (heap_dl[a] >= mdl)
                break;
            heap_dl[i] = heap_dl[a];
            heap_tag[i] = heap_tag[a];
            i = a;
        end
        heap_dl[i] = mdl;
        heap_tag[i] = mtag;
    endfunction

    // predict the events one accepted word causes
    function automatic void predict_timer_events(input timer_req_t w);
        logic [32:0] sum;
        logic [31:0] dl;
        timer_evt_t  ev;
        int          n;
        if (w.action == mhtq_pkg::ACT_ADD)
        begin
            sum = {1'b0, w.now} + {13'd0, w.delay};
            dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            ev.kind = (heap_count >= CAP) ? mhtq_pkg::KIND_REJECTED
                                          : mhtq_pkg::KIND_ACCEPTED;
            if (heap_count < CAP)
                heap_insert(dl, w.tag);
            ev.fired_tag = w.tag;
            ev.deadline = dl;
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
        else
        begin
            n = 0;
            while (n < mhtq_pkg::MAX_RESULTS && heap_count > 0 && heap_dl[0] <= w.now)
            begin
                ev.kind = mhtq_pkg::KIND_FIRED;
                ev.fired_tag = heap_tag[0];
                ev.deadline = heap_dl[0];
                ev.last = 1'b0;
                heap_pop_root();
                expected_events.push_back(ev);
                n++;
            end
            if (n > 0)
                expected_events[$].last = 1'b1;
        end
    endfunction

    function automatic timer_req_t make_word(input logic act, input logic [31:0] t,
                                             input logic [19:0] d, input logic [15:0] id);
        timer_req_t w;
        w.action = act;
        w.now = t;
        w.delay = d;
        w.tag = id;
        return w;
    endfunction

    // drive input words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= 1'b0;
            now <= '0;
            delay <= '0;
            tag <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_timer_events({action, now, delay, tag});
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (!hold_sender && pending_words.size() > 0)
                begin
                    {action, now, delay, tag} <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // check output words and drive stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch("unexpected word tag", 32'(fired_tag), '0);
                end
                else
                begin
                    timer_evt_t want;
                    want = expected_events.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (fired_tag !== want.fired_tag)
                        report_mismatch("fired_tag", fired_tag, want.fired_tag);
                    if (deadline !== want.deadline)
                        report_mismatch("deadline", deadline, want.deadline);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired");
                $display("status: fail");
                $finish;
            end
            if (receiver_hold > 0)
            begin
                receiver_hold--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_events.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] clock_now;
        int k;
        int j;
        fail_count = 0;
        heap_count = 0;
        quiet_tail = 1'b0;
        hold_sender = 1'b0;
        receiver_hold = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, saturation, ties, empty expire
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, 20'hFFFFF,
                                          16'hFFFF));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'h0, 20'h0, 16'h0));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'hFFFF_FFFF, 20'hFFFFF,
                                          16'hFFFF));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'hFFFF_FF00, 20'hFFFFF,
                                          16'h5A5A));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'd100, 20'd5, 16'h0001));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'd100, 20'd5, 16'h0002));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'd104, 20'd1, 16'h0003));
        pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'd50, 20'd0, 16'hA5A5));
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'd104, 20'd0, 16'd0));
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'd105, 20'hFFFFF,
                                          16'hFFFF));
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'hFFFF_FFFE, 20'd0,
                                          16'd0));
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, 20'd0,
                                          16'd0));
        wait_drained();

        // fill past capacity while the receiver holds off, then fire all 64
        receiver_hold = 300;
        for (k = 0; k < CAP + 3; k++)
            pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, 32'd1000,
                20'($urandom_range(0, 3)), 16'(k)));
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, 20'd0,
                                          16'd0));
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, 20'd0,
                                          16'd0));
        wait_drained();

        // random: mostly adds with clustered deadlines and random expires
        clock_now = 32'd0;
        for (k = 0; k < 340; k++)
        begin
            if (k == 170)
            begin
                // wait until everything is out, then pause the sender
                wait_drained();
                hold_sender = 1'b1;
                repeat ($urandom_range(5, 20)) @(posedge clk);
                hold_sender = 1'b0;
            end
            if (k == 280)
            begin
                wait_drained();
                quiet_tail = 1'b1;
            end
            j = $urandom_range(0, 99);
            if (j < 3)
                clock_now = $urandom;
            else
                clock_now = clock_now + $urandom_range(0, 40);
            if (j < 55)
                pending_words.push_back(make_word(mhtq_pkg::ACT_ADD, clock_now,
                    (j < 8) ? 20'($urandom) : 20'($urandom_range(0, 120)),
                    16'($urandom)));
            else
                pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, clock_now,
                    20'($urandom), 16'($urandom)));
        end
        pending_words.push_back(make_word(mhtq_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, 20'd0,
                                          16'd0));
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
